/* src/tpsa_pkg.sv */
package tpsa_pkg;

  localparam int SLOTS      = 256;
  localparam int PAGE_BYTES = 4096;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  localparam logic [31:0]      PAGE_STEP = 32'(PAGE_BYTES);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SLOTS - 1);

  localparam logic OP_QUERY = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  typedef struct packed {
    logic        used;
    logic [7:0]  owner;
    logic [31:0] low_tag;
    logic [31:0] high_tag;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

/* src/tpsa_if.sv */
interface tpsa_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [7:0]  guest_id;
  logic [31:0] low_guest_addr;
  logic [31:0] high_guest_addr;

  modport source (output valid, operation, guest_id, low_guest_addr, high_guest_addr,
                  input ready);
  modport sink   (input valid, operation, guest_id, low_guest_addr, high_guest_addr,
                  output ready);
endinterface

interface tpsa_rsp_if;
  logic        valid;
  logic        ready;
  logic        page_found;
  logic [31:0] page_address;
  logic        pool_full;
  logic [8:0]  used_slots;

  modport source (output valid, page_found, page_address, pool_full, used_slots,
                  input ready);
  modport sink   (input valid, page_found, page_address, pool_full, used_slots,
                  output ready);
endinterface

interface tpsa_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* src/tpsa_cell.sv */
module tpsa_cell (
  input  logic               clk,
  input  logic               rst,
  input  tpsa_pkg::cell_ctl_t ctl,
  input  tpsa_pkg::entry_t   nbr_in,
  input  tpsa_pkg::entry_t   new_in,
  output tpsa_pkg::entry_t   q
);
  import tpsa_pkg::*;

  logic        slot_used;
  logic [7:0]  slot_owner;
  logic [31:0] slot_low;
  logic [31:0] slot_high;

  // used bit resets; tags are only read behind a set used bit
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used <= 1'b0;
    end else if (ctl.shift) begin
      slot_used <= ctl.load ? new_in.used : nbr_in.used;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      slot_owner <= ctl.load ? new_in.owner    : nbr_in.owner;
      slot_low   <= ctl.load ? new_in.low_tag  : nbr_in.low_tag;
      slot_high  <= ctl.load ? new_in.high_tag : nbr_in.high_tag;
    end
  end

  assign q = '{used: slot_used, owner: slot_owner, low_tag: slot_low, high_tag: slot_high};
endmodule

/* src/tpsa_ctrl.sv */
module tpsa_ctrl (
  input  logic                clk,
  input  logic                rst,
  tpsa_req_if.sink            req,
  tpsa_rsp_if.source          rsp,
  input  logic [31:0]         memory_base,
  input  tpsa_pkg::entry_t    head,
  input  tpsa_pkg::entry_t    next,
  output tpsa_pkg::cell_ctl_t ctl,
  output tpsa_pkg::entry_t    new_entry
);
  import tpsa_pkg::*;

  typedef enum logic [1:0] {IDLE, QUERY, ALLOC, RESP} state_t;

  state_t           state;
  logic [IDX_W-1:0] hidx;
  logic [IDX_W-1:0] hidx_next;
  logic [31:0]      off;
  logic [31:0]      off_next;
  logic [IDX_W-1:0] step;
  logic [CNT_W-1:0] count;
  logic             found;
  logic             full;
  logic             op;
  logic [7:0]       gid;
  logic [31:0]      lo;
  logic [31:0]      hi;
  logic             head_match;
  logic             last_step;

  logic             rsp_valid;
  logic             rsp_found;
  logic [31:0]      rsp_addr;
  logic             rsp_full;
  logic [8:0]       rsp_used;

  assign hidx_next  = (hidx == LAST_IDX) ? '0 : hidx + 1'b1;
  assign off_next   = (hidx == LAST_IDX) ? '0 : off + PAGE_STEP;
  assign last_step  = (step == LAST_IDX);
  assign head_match = head.used && (head.owner == gid) &&
                      (head.low_tag == lo) && (head.high_tag == hi);

  assign new_entry = '{used: 1'b1, owner: gid, low_tag: lo, high_tag: hi};

  always_comb begin
    ctl.shift = (state == QUERY) || (state == ALLOC);
    ctl.load  = (state == ALLOC) && !next.used;
  end

  assign req.ready = (state == IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      hidx      <= '0;
      off       <= '0;
      step      <= '0;
      count     <= '0;
      found     <= 1'b0;
      full      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // RESP reloads the output register itself
      if (rsp_valid && rsp.ready && (state != RESP)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (req.valid) begin
            op    <= req.operation;
            gid   <= req.guest_id;
            lo    <= req.low_guest_addr;
            hi    <= req.high_guest_addr;
            step  <= '0;
            found <= 1'b0;
            full  <= 1'b0;
            state <= (req.operation == OP_ALLOC) ? ALLOC : QUERY;
          end
        end
        QUERY: begin
          found <= found | head_match;
          hidx  <= hidx_next;
          off   <= off_next;
          step  <= step + 1'b1;
          if (last_step) begin
            state <= RESP;
          end
        end
        ALLOC: begin
          hidx <= hidx_next;
          off  <= off_next;
          step <= step + 1'b1;
          if (!next.used) begin
            count <= count + 1'b1;
            state <= RESP;
          end else if (last_step) begin
            full  <= 1'b1;
            state <= RESP;
          end
        end
        RESP: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid <= 1'b1;
            rsp_found <= (op == OP_QUERY) && found;
            rsp_full  <= (op == OP_ALLOC) && full;
            rsp_addr  <= ((op == OP_ALLOC) && !full) ? memory_base + off : 32'd0;
            rsp_used  <= 9'(count);
            state     <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.page_found   = rsp_found;
  assign rsp.page_address = rsp_addr;
  assign rsp.pool_full    = rsp_full;
  assign rsp.used_slots   = rsp_used;
endmodule

/* src/tagged_page_slot_allocator.sv */
// Next-fit page slot allocator over a table of SLOTS slots, each holding a used
// mark, an owner guest id and two guest address tags. The slots live in a ring
// of cells that rotates by one slot per cycle past a head cell while a request
// is served; control keeps the slot index and page offset of whatever sits at
// the head, and the head always rests on the last slot allocated. A query
// (operation 0) is accepted, makes a full revolution comparing the head cell,
// and then posts the response. An allocation (operation 1) rotates until the
// slot behind the head is free and loads the new tags into the head as it
// shifts, so it rotates as far as the first free slot (distance 1..SLOTS);
// with no free slot it makes a full revolution and reports pool_full with
// address 0. The response sits in an output register, so a new request is
// taken while it waits. Used marks clear at reset; there is no clearing pass.
// Write memory_base only while the block is idle.
module tagged_page_slot_allocator (
  input  logic       clk,
  input  logic       rst,
  tpsa_req_if.sink   req,
  tpsa_rsp_if.source rsp,
  tpsa_cfg_if.sink   cfg
);
  import tpsa_pkg::*;

  logic [31:0] memory_base;
  entry_t      cell_q [SLOTS];
  entry_t      new_entry;
  cell_ctl_t   ctl;
  cell_ctl_t   tail_ctl;

  // configuration: always ready, one register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      memory_base <= '0;
    end else if (cfg.valid) begin
      memory_base <= cfg.data;
    end
  end

  // sequencer: holds the request, drives the rotation, builds the response
  tpsa_ctrl ctrl (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .memory_base (memory_base),
    .head        (cell_q[0]),
    .next        (cell_q[1]),
    .ctl         (ctl),
    .new_entry   (new_entry)
  );

  // only the head cell can take a new entry; the rest just shift
  always_comb begin
    tail_ctl.shift = ctl.shift;
    tail_ctl.load  = 1'b0;
  end

  // ring: each cell takes its upper neighbor, the top cell wraps to the head
  for (genvar i = 0; i < SLOTS; i++) begin : g_ring
    if (i == 0) begin : g_head
      tpsa_cell slot_cell (
        .clk    (clk),
        .rst    (rst),
        .ctl    (ctl),
        .nbr_in (cell_q[1]),
        .new_in (new_entry),
        .q      (cell_q[0])
      );
    end else begin : g_body
      tpsa_cell slot_cell (
        .clk    (clk),
        .rst    (rst),
        .ctl    (tail_ctl),
        .nbr_in (cell_q[(i + 1) % SLOTS]),
        .new_in (new_entry),
        .q      (cell_q[i])
      );
    end
  end

  // claim only a slot that is free
  a_claim_free: assert property (@(posedge clk) disable iff (rst)
    ctl.load |-> !cell_q[1].used)
    else $error("allocation claimed a used slot");

  // a claimed slot lands in the head cell marked used
  a_claim_lands: assert property (@(posedge clk) disable iff (rst)
    ctl.load |=> cell_q[0].used)
    else $error("claimed slot not marked used at head");

  // a full pool reports no address and no match
  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.pool_full) |-> (rsp.page_address == 32'd0 && !rsp.page_found))
    else $error("pool_full response carries address or match");

endmodule
